// ===== rtl/tcpq_pkg.sv =====
// Package for the two-class priority queue: sizes, status and command codes,
// and the pointer wrap helper. No dependencies.
`default_nettype none

package tcpq_pkg;

   localparam int MAX_DEPTH  = 64;
   localparam int DATA_BITS  = 16;
   localparam int PTR_BITS   = $clog2(MAX_DEPTH);
   localparam int LEVEL_BITS = $clog2(MAX_DEPTH + 1);
   localparam int CAP_BITS   = 7;
   localparam int STAT_BITS  = 2;
   localparam int OUT_LEVEL_BITS = 7;

   typedef logic [PTR_BITS-1:0]   ptr_type;
   typedef logic [LEVEL_BITS-1:0] level_type;
   typedef logic [CAP_BITS-1:0]   cap_type;
   typedef logic [STAT_BITS-1:0]  status_type;
   typedef logic signed [DATA_BITS-1:0] word_type;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam status_type ST_INSERTED = 2'd0;
   localparam status_type ST_REMOVED  = 2'd1;
   localparam status_type ST_FULL     = 2'd2;
   localparam status_type ST_EMPTY    = 2'd3;

   // Step a circular pointer; wraps to zero once it reaches the capacity.
   function automatic ptr_type next_ptr(input ptr_type ptr, input level_type cap);
      logic [PTR_BITS:0] nxt;
      nxt = {1'b0, ptr} + {{PTR_BITS{1'b0}}, 1'b1};
      next_ptr = (32'(nxt) >= 32'(cap)) ? '0 : nxt[PTR_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tcpq_if.sv =====
// Valid/ready channel interfaces for the request and response beats.
// Depends on tcpq_pkg.
`default_nettype none

interface tcpq_req_if;
   import tcpq_pkg::*;
   logic     valid;
   logic     ready;
   logic     command;
   logic     urgent;
   word_type payload;

   modport source (output valid, command, urgent, payload, input ready);
   modport sink   (input valid, command, urgent, payload, output ready);
endinterface

interface tcpq_rsp_if;
   import tcpq_pkg::*;
   logic       valid;
   logic       ready;
   status_type status;
   word_type   out_payload;
   logic       out_urgent;
   logic [OUT_LEVEL_BITS-1:0] urgent_level;
   logic [OUT_LEVEL_BITS-1:0] normal_level;

   modport source (output valid, status, out_payload, out_urgent, urgent_level,
                   normal_level, input ready);
   modport sink   (input valid, status, out_payload, out_urgent, urgent_level,
                   normal_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/two_class_priority_queue_top.sv =====
// Two-class strict-priority queue, top level.
// Depends on tcpq_pkg, tcpq_if and tcpq_ram.
//
// Usage:
//   req_ch carries one command per beat: insert (payload into the urgent or
//   normal FIFO) or remove (oldest urgent entry, else oldest normal entry).
//   rsp_ch returns exactly one beat per request with status and both levels.
//   csr_we/csr_wdata write the per-FIFO capacity (1..64; 0 as 1, 65+ as 64).
// Timing:
//   An insert, a refused insert or an empty remove answers in the cycle after
//   the request beat. A remove answers once the entry has passed the FIFO RAM
//   read register and then the response register. Throughput is one beat
//   every cycle for inserts while rsp_ch.ready stays high; a remove takes no
//   new request until its RAM read has reached the response register.
// Reset:
//   Synchronous, active high. Both FIFOs empty, capacity 64. RAM contents
//   are not cleared; an entry is only read after it was written.
// Stall:
//   The response register holds its beat while rsp_ch.ready is low; a new
//   request is taken in the cycle the held beat leaves.
`default_nettype none

module two_class_priority_queue_top (
   input  wire logic             clock,
   input  wire logic             reset,
   tcpq_req_if.sink              req_ch,
   tcpq_rsp_if.source            rsp_ch,
   input  wire logic             csr_we,
   input  wire tcpq_pkg::cap_type csr_wdata
);
   import tcpq_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic      state_ff, state_in;
   cap_type   cap_ff, cap_in;
   ptr_type   u_rd_ff, u_rd_in, u_wr_ff, u_wr_in;
   ptr_type   n_rd_ff, n_rd_in, n_wr_ff, n_wr_in;
   level_type u_fill_ff, u_fill_in, n_fill_ff, n_fill_in;
   logic      pop_urgent_ff, pop_urgent_in;

   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   word_type   rsp_payload_ff, rsp_payload_in;
   logic       rsp_urgent_ff, rsp_urgent_in;
   logic [OUT_LEVEL_BITS-1:0] rsp_ulev_ff, rsp_ulev_in, rsp_nlev_ff, rsp_nlev_in;

   level_type cap_eff;
   logic      accept;
   logic      u_we, n_we, u_re, n_re;
   word_type  u_rdata, n_rdata;

   tcpq_ram #(.WIDTH(DATA_BITS), .DEPTH(MAX_DEPTH)) u_urgent_ram (
      .clock   (clock),
      .wr_en   (u_we),
      .wr_addr (u_wr_ff),
      .wr_data (req_ch.payload),
      .rd_en   (u_re),
      .rd_addr (u_rd_ff),
      .rd_data (u_rdata)
   );

   tcpq_ram #(.WIDTH(DATA_BITS), .DEPTH(MAX_DEPTH)) u_normal_ram (
      .clock   (clock),
      .wr_en   (n_we),
      .wr_addr (n_wr_ff),
      .wr_data (req_ch.payload),
      .rd_en   (n_re),
      .rd_addr (n_rd_ff),
      .rd_data (n_rdata)
   );

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = level_type'(1);
      end else if (32'(cap_ff) > MAX_DEPTH) begin
         cap_eff = level_type'(MAX_DEPTH);
      end else begin
         cap_eff = level_type'(cap_ff);
      end
   end

   assign req_ch.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in       = state_ff;
      cap_in         = csr_we ? csr_wdata : cap_ff;
      u_rd_in        = u_rd_ff;
      u_wr_in        = u_wr_ff;
      n_rd_in        = n_rd_ff;
      n_wr_in        = n_wr_ff;
      u_fill_in      = u_fill_ff;
      n_fill_in      = n_fill_ff;
      pop_urgent_in  = pop_urgent_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_urgent_in  = rsp_urgent_ff;
      rsp_ulev_in    = rsp_ulev_ff;
      rsp_nlev_in    = rsp_nlev_ff;
      u_we = 1'b0;
      n_we = 1'b0;
      u_re = 1'b0;
      n_re = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_payload_in = '0;
               rsp_urgent_in  = 1'b0;
               if (req_ch.command == CMD_INSERT) begin
                  rsp_valid_in = 1'b1;
                  if (req_ch.urgent) begin
                     if (u_fill_ff >= cap_eff) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        rsp_status_in = ST_INSERTED;
                        u_we      = 1'b1;
                        u_wr_in   = next_ptr(u_wr_ff, cap_eff);
                        u_fill_in = u_fill_ff + level_type'(1);
                     end
                  end else begin
                     if (n_fill_ff >= cap_eff) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        rsp_status_in = ST_INSERTED;
                        n_we      = 1'b1;
                        n_wr_in   = next_ptr(n_wr_ff, cap_eff);
                        n_fill_in = n_fill_ff + level_type'(1);
                     end
                  end
               end else if (u_fill_ff != '0) begin
                  u_re          = 1'b1;
                  pop_urgent_in = 1'b1;
                  u_rd_in       = next_ptr(u_rd_ff, cap_eff);
                  u_fill_in     = u_fill_ff - level_type'(1);
                  state_in      = S_READ;
               end else if (n_fill_ff != '0) begin
                  n_re          = 1'b1;
                  pop_urgent_in = 1'b0;
                  n_rd_in       = next_ptr(n_rd_ff, cap_eff);
                  n_fill_in     = n_fill_ff - level_type'(1);
                  state_in      = S_READ;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_EMPTY;
               end
               rsp_ulev_in = OUT_LEVEL_BITS'(u_fill_in);
               rsp_nlev_in = OUT_LEVEL_BITS'(n_fill_in);
            end
         end
         S_READ: begin
            // RAM data is valid now; levels already reflect the pop
            state_in       = S_IDLE;
            rsp_valid_in   = 1'b1;
            rsp_status_in  = ST_REMOVED;
            rsp_payload_in = pop_urgent_ff ? u_rdata : n_rdata;
            rsp_urgent_in  = pop_urgent_ff;
            rsp_ulev_in    = OUT_LEVEL_BITS'(u_fill_ff);
            rsp_nlev_in    = OUT_LEVEL_BITS'(n_fill_ff);
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cap_ff        <= cap_type'(64);
         u_rd_ff       <= '0;
         u_wr_ff       <= '0;
         n_rd_ff       <= '0;
         n_wr_ff       <= '0;
         u_fill_ff     <= '0;
         n_fill_ff     <= '0;
         pop_urgent_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         u_rd_ff       <= u_rd_in;
         u_wr_ff       <= u_wr_in;
         n_rd_ff       <= n_rd_in;
         n_wr_ff       <= n_wr_in;
         u_fill_ff     <= u_fill_in;
         n_fill_ff     <= n_fill_in;
         pop_urgent_ff <= pop_urgent_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_urgent_ff  <= rsp_urgent_in;
      rsp_ulev_ff    <= rsp_ulev_in;
      rsp_nlev_ff    <= rsp_nlev_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.out_payload  = rsp_payload_ff;
   assign rsp_ch.out_urgent   = rsp_urgent_ff;
   assign rsp_ch.urgent_level = rsp_ulev_ff;
   assign rsp_ch.normal_level = rsp_nlev_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(u_fill_ff) <= MAX_DEPTH) && (32'(n_fill_ff) <= MAX_DEPTH))
      else $error("fill level above depth");

   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !rsp_valid_ff)
      else $error("response register busy during RAM read");

   a_remove_reads: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_ch.command == CMD_REMOVE) && (u_fill_ff != '0))
      |=> (state_ff == S_READ) && pop_urgent_ff)
      else $error("urgent entry not popped first");

   a_removed_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> rsp_valid_ff && (rsp_status_ff == ST_REMOVED))
      else $error("read did not produce a removed beat");
`endif

endmodule

`default_nettype wire

// ===== rtl/tcpq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tcpq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== dv/tcpq_queue_checker.sv =====
`timescale 1ns / 1ps
// Checker for the two-class priority queue: mirrors both FIFOs from the accepted
// request beats and compares every response beat field by field.
// Depends on tcpq_pkg and the channel interfaces in tcpq_if.
module tcpq_queue_checker (
   input  logic              clock,
   input  logic              reset,
   tcpq_req_if               req_ch,
   tcpq_rsp_if               rsp_ch,
   input  logic              csr_we,
   input  tcpq_pkg::cap_type csr_wdata,
   output int                mismatch_count,
   output int                answers_owed,
   output int                entries_held
);
   import tcpq_pkg::*;

   localparam int NORMAL = 0;
   localparam int URGENT = 1;

   typedef struct {
      status_type                status;
      word_type                  value;
      logic                      from_urgent;
      logic [OUT_LEVEL_BITS-1:0] urgent_level;
      logic [OUT_LEVEL_BITS-1:0] normal_level;
   } queue_answer_type;

   // [0] normal class, [1] urgent class
   word_type         held_words [2][MAX_DEPTH];
   int unsigned      rd_at [2];
   int unsigned      wr_at [2];
   int unsigned      class_fill [2];
   cap_type          capacity;
   queue_answer_type answers_due [$];

   function automatic int unsigned depth_in_use();
      if (capacity == '0) return 1;
      if (capacity > MAX_DEPTH) return MAX_DEPTH;
      return capacity;
   endfunction

   function automatic int unsigned wrap_next(input int unsigned ptr, input int unsigned lim);
      return (ptr + 1 >= lim) ? 0 : ptr + 1;
   endfunction

   function automatic queue_answer_type apply_command(input logic cmd, input logic urg,
                                                      input word_type value);
      queue_answer_type ans;
      int unsigned      lim;
      int               src;
      lim = depth_in_use();
      ans.value = '0;
      ans.from_urgent = 1'b0;
      if (cmd == CMD_INSERT) begin
         src = urg ? URGENT : NORMAL;
         // fill may sit above a freshly lowered capacity
         if (class_fill[src] >= lim) begin
            ans.status = ST_FULL;
         end else begin
            held_words[src][wr_at[src] % MAX_DEPTH] = value;
            wr_at[src] = wrap_next(wr_at[src], lim);
            class_fill[src]++;
            ans.status = ST_INSERTED;
         end
      end else if (class_fill[URGENT] == 0 && class_fill[NORMAL] == 0) begin
         ans.status = ST_EMPTY;
      end else begin
         src = (class_fill[URGENT] != 0) ? URGENT : NORMAL;
         ans.value = held_words[src][rd_at[src] % MAX_DEPTH];
         rd_at[src] = wrap_next(rd_at[src], lim);
         class_fill[src]--;
         ans.from_urgent = (src == URGENT);
         ans.status = ST_REMOVED;
      end
      ans.urgent_level = OUT_LEVEL_BITS'(class_fill[URGENT]);
      ans.normal_level = OUT_LEVEL_BITS'(class_fill[NORMAL]);
      return ans;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      queue_answer_type want;
      if (reset) begin
         rd_at = '{0, 0};
         wr_at = '{0, 0};
         class_fill = '{0, 0};
         capacity = cap_type'(MAX_DEPTH);
         answers_due.delete();
      end else begin
         // compare before predicting, so a stray beat is never matched to a new request
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (answers_due.size() == 0) begin
               report_mismatch("response beat with no request outstanding");
            end else begin
               want = answers_due.pop_front();
               if (rsp_ch.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_ch.status, want.status));
               if (rsp_ch.out_payload !== want.value)
                  report_mismatch($sformatf("out_payload %0d, expected %0d",
                                            rsp_ch.out_payload, want.value));
               if (rsp_ch.out_urgent !== want.from_urgent)
                  report_mismatch($sformatf("out_urgent %0b, expected %0b",
                                            rsp_ch.out_urgent, want.from_urgent));
               if (rsp_ch.urgent_level !== want.urgent_level)
                  report_mismatch($sformatf("urgent_level %0d, expected %0d",
                                            rsp_ch.urgent_level, want.urgent_level));
               if (rsp_ch.normal_level !== want.normal_level)
                  report_mismatch($sformatf("normal_level %0d, expected %0d",
                                            rsp_ch.normal_level, want.normal_level));
            end
         end
         // a request on the same edge as a capacity write still sees the old capacity
         if (req_ch.valid && req_ch.ready)
            answers_due.push_back(apply_command(req_ch.command, req_ch.urgent,
                                                req_ch.payload));
         if (csr_we) capacity = csr_wdata;
      end
      answers_owed = answers_due.size();
      entries_held = class_fill[URGENT] + class_fill[NORMAL];
   end

endmodule

// ===== dv/tb_two_class_priority_queue_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the two-class priority queue: clock, reset, request and
// capacity stimulus, response back-pressure and the verdict.
// Depends on tcpq_pkg, tcpq_if, two_class_priority_queue_top and tcpq_queue_checker.
module tb_two_class_priority_queue_top;
   import tcpq_pkg::*;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_BEATS     = 150;

   typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic    clock;
   logic    reset;
   logic    csr_we;
   cap_type csr_wdata;
   int      mismatch_count;
   int      answers_owed;
   int      entries_held;
   int      burst_left = 0;
   int      holds_asked = 0;
   int      holds_served = 0;

   tcpq_req_if req_ch ();
   tcpq_rsp_if rsp_ch ();

   two_class_priority_queue_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   tcpq_queue_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .answers_owed   (answers_owed),
      .entries_held   (entries_held)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // One request beat; opens a new burst after a random gap when the last one ran out.
   task automatic offer_command(input logic cmd, input logic urg, input word_type value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.urgent  <= urg;
      req_ch.payload <= value;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (answers_owed != 0);
   endtask

   task automatic write_capacity(input cap_type value);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Leaves both FIFOs empty with read and write pointers together.
   task automatic empty_queues();
      int n;
      settle();
      n = entries_held;
      repeat (n) offer_command(CMD_REMOVE, 1'($urandom), word_type'($urandom));
      settle();
   endtask

   initial begin : receiver
      stall_mode_type mode;
      int             left;
      mode = STALL_NONE;
      left = 0;
      rsp_ch.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (holds_served != holds_asked) begin
            holds_served++;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            if (left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
               STALL_NONE: begin
                  rsp_ch.ready <= 1'b1;
               end
               STALL_HALF: begin
                  rsp_ch.ready <= 1'($urandom_range(0, 1));
               end
               STALL_HEAVY: begin
                  rsp_ch.ready <= ($urandom_range(0, 4) == 0);
               end
               default: begin
                  rsp_ch.ready <= (left % 3 == 0);
               end
            endcase
         end
      end
   end

   initial begin : stimulus
      int      insert_pct;
      int      urgent_pct;
      cap_type phase_caps [12];
      phase_caps = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd65, 7'd3, 7'd2, 7'd8, 7'd40, 7'd16,
                     7'd100, 7'd5};
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.command = CMD_INSERT;
      req_ch.urgent  = 1'b0;
      req_ch.payload = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // remove from empty queues, stray urgent bit and payload ignored
      offer_command(CMD_REMOVE, 1'b1, 16'hFFFF);
      offer_command(CMD_INSERT, 1'b0, 16'h8000);
      offer_command(CMD_INSERT, 1'b0, 16'h7FFF);
      offer_command(CMD_INSERT, 1'b0, 16'h0001);
      settle();
      // shrink below the normal fill: that class refuses, its read pointer wraps early
      write_capacity(7'd2);
      offer_command(CMD_INSERT, 1'b0, 16'h1234);
      offer_command(CMD_INSERT, 1'b1, 16'h0000);
      offer_command(CMD_INSERT, 1'b1, 16'hFFFF);
      offer_command(CMD_INSERT, 1'b1, 16'h5555);
      repeat (5) offer_command(CMD_REMOVE, 1'b0, 16'h0000);
      // write pointer past the capacity wraps; the next remove brings the pointers together
      offer_command(CMD_INSERT, 1'b0, 16'h0F0F);
      offer_command(CMD_REMOVE, 1'b1, 16'hAAAA);
      settle();

      foreach (phase_caps[p]) begin
         write_capacity(phase_caps[p]);
         if (p == 2 || p == 8) holds_asked++;
         insert_pct = (p % 4 == 0) ? 95 : 25 + 20 * $urandom_range(0, 3);
         urgent_pct = $urandom_range(10, 90);
         repeat (PHASE_BEATS)
            offer_command(($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE,
                          ($urandom_range(0, 99) < urgent_pct), word_type'($urandom));
         empty_queues();
      end

      settle();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && answers_owed == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
